FILE: design/bbe_pkg.sv
`timescale 1ns / 1ps

package bbe_pkg;

    localparam int unsigned BITMAP_W = 16;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned GAIN_W   = 10;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned LANES    = 16;

    localparam logic [31:0]       HASH_MUL_K   = 32'd1103515245;
    localparam logic [31:0]       HASH_MUL_MIX = 32'h7feb352d;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 10'd90;

    typedef struct packed {
        logic [BITMAP_W-1:0] cover_bitmap;
        logic [LEVEL_W-1:0]  cover_high;
        logic [LEVEL_W-1:0]  cover_low;
        logic [BITMAP_W-1:0] payload_bits;
        logic [COUNT_W-1:0]  payload_count;
    } t_bbe_in;

    typedef struct packed {
        logic [BITMAP_W-1:0] stego_bitmap;
        logic [LEVEL_W-1:0]  stego_high;
        logic [LEVEL_W-1:0]  stego_low;
        logic [LEVEL_W-1:0]  level_spread;
    } t_bbe_out;

    // per-lane constant term k * HASH_MUL_K, modulo 2^32
    function automatic logic [31:0] hash_k_term(input logic [POS_W-1:0] k);
        logic [63:0] prod;
        prod = {60'd0, k} * {32'd0, HASH_MUL_K};
        return prod[31:0];
    endfunction

endpackage

FILE: design/btc_block_bit_embedder_top.sv
`timescale 1ns / 1ps

// AMBTC block bit embedder
// requests: drive i_in and pulse start for one cycle; a request is taken at
// any rising edge where start is high and busy is low. busy stays low, so a
// new request may be issued every cycle.
// results: o_result is valid for exactly one cycle while o_done is high.
// a request taken at a rising edge passes through stages r1 to r6 in order,
// and o_done is r6_v. throughput is one request per cycle, set by the six-stage
// pipeline (input capture, 16 parallel hash lanes, bitmap merge, popcount and
// gain times spread, correction product, rounding with clamp and swap).
// the receiver cannot stall; results are never held back.
// configuration: i_cfg_valid / o_cfg_ready write the 10-bit Q2.8 gain;
// o_cfg_ready is always high. write the gain only while no request is in
// flight.
// reset (i_rst_n low, synchronous) clears all stage valids and sets the gain
// to 90; requests in flight are dropped.
module btc_block_bit_embedder_top
    import bbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_bbe_in           i_in,
    output logic              o_done,
    output t_bbe_out          o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [GAIN_W-1:0] i_cfg_data
);

    function automatic logic [COUNT_W-1:0] ones16(input logic [BITMAP_W-1:0] x);
        logic [COUNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < BITMAP_W; i++) begin
            c = c + {{(COUNT_W-1){1'b0}}, x[i]};
        end
        return c;
    endfunction

    logic [GAIN_W-1:0] r_gain;

    // stage 1: capture
    logic    r1_v;
    t_bbe_in r1_in;

    // stage 2: hash lanes
    logic                r2_v;
    logic [POS_W-1:0]    r2_pos [LANES];
    logic [POS_W-1:0]    n2_pos [LANES];
    logic [LANES-1:0]    r2_act;
    logic [LANES-1:0]    n2_act;
    logic [BITMAP_W-1:0] r2_bm;
    logic [BITMAP_W-1:0] r2_pay;
    logic [LEVEL_W-1:0]  r2_hi;
    logic [LEVEL_W-1:0]  r2_lo;

    // stage 3: merged bitmap
    logic                r3_v;
    logic [BITMAP_W-1:0] r3_st;
    logic [BITMAP_W-1:0] n3_st;
    logic [BITMAP_W-1:0] r3_bm;
    logic [LEVEL_W-1:0]  r3_hi;
    logic [LEVEL_W-1:0]  r3_lo;

    // stage 4: delta ones and gain times spread
    logic                r4_v;
    logic [BITMAP_W-1:0] r4_st;
    logic signed [5:0]   r4_delta;
    logic signed [5:0]   n4_delta;
    logic signed [19:0]  r4_gs;
    logic signed [19:0]  n4_gs;
    logic [LEVEL_W-1:0]  r4_hi;
    logic [LEVEL_W-1:0]  r4_lo;

    // stage 5: correction product
    logic                r5_v;
    logic [BITMAP_W-1:0] r5_st;
    logic signed [23:0]  r5_p;
    logic signed [25:0]  n5_full;
    logic [LEVEL_W-1:0]  r5_hi;
    logic [LEVEL_W-1:0]  r5_lo;

    // stage 6: output
    logic     r6_v;
    t_bbe_out r6_out;
    t_bbe_out n6_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r6_v;
    assign o_result    = r6_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gain <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // hash lanes
    always_comb begin
        logic [31:0] m0;
        logic [18:0] m1;
        logic [37:0] prod;
        for (int k = 0; k < LANES; k++) begin
            m0 = {16'd0, r1_in.cover_bitmap} ^ {16'd0, r1_in.cover_high, 8'd0}
               ^ {24'd0, r1_in.cover_low} ^ hash_k_term(POS_W'(k));
            m1 = m0[18:0] ^ {3'd0, m0[31:16]};
            prod = {19'd0, m1} * {19'd0, HASH_MUL_MIX[18:0]};
            n2_pos[k] = prod[3:0] ^ prod[18:15];
            n2_act[k] = r1_in.payload_count > COUNT_W'(k);
        end
    end

    // each position takes the last active lane that hits it
    always_comb begin
        for (int n = 0; n < BITMAP_W; n++) begin
            n3_st[n] = r2_bm[n];
            for (int k = 0; k < LANES; k++) begin
                if (r2_act[k] && (r2_pos[k] == POS_W'(n))) begin
                    n3_st[n] = r2_pay[k];
                end
            end
        end
    end

    always_comb begin
        n4_delta = $signed({1'b0, ones16(r3_st)}) - $signed({1'b0, ones16(r3_bm)});
        n4_gs    = 20'($signed({1'b0, r_gain}))
                 * (20'($signed({1'b0, r3_hi})) - 20'($signed({1'b0, r3_lo})));
        n5_full  = 26'(r4_gs) * 26'(r4_delta);
    end

    // round half to even, subtract, clamp, order
    always_comb begin
        logic              neg;
        logic [22:0]       mag;
        logic [10:0]       q;
        logic [11:0]       rem;
        logic              up;
        logic [10:0]       qr;
        logic signed [12:0] corr;
        logic signed [12:0] sh;
        logic signed [12:0] sl;
        logic [LEVEL_W-1:0] ch;
        logic [LEVEL_W-1:0] cl;
        neg  = r5_p[23];
        mag  = neg ? 23'(-r5_p) : r5_p[22:0];
        q    = mag[22:12];
        rem  = mag[11:0];
        up   = (rem > 12'd2048) || ((rem == 12'd2048) && q[0]);
        qr   = q + {10'd0, up};
        corr = neg ? -$signed({2'b00, qr}) : $signed({2'b00, qr});
        sh   = $signed({5'd0, r5_hi}) - corr;
        sl   = $signed({5'd0, r5_lo}) - corr;
        if (sh < 0) begin
            ch = '0;
        end else if (sh > 13'sd255) begin
            ch = '1;
        end else begin
            ch = sh[7:0];
        end
        if (sl < 0) begin
            cl = '0;
        end else if (sl > 13'sd255) begin
            cl = '1;
        end else begin
            cl = sl[7:0];
        end
        n6_out.stego_bitmap = r5_st;
        if (ch < cl) begin
            n6_out.stego_high = cl;
            n6_out.stego_low  = ch;
        end else begin
            n6_out.stego_high = ch;
            n6_out.stego_low  = cl;
        end
        n6_out.level_spread = n6_out.stego_high - n6_out.stego_low;
    end

    always_ff @(posedge i_clk) begin
        r1_in <= i_in;
        for (int k = 0; k < LANES; k++) begin
            r2_pos[k] <= n2_pos[k];
        end
        r2_act   <= n2_act;
        r2_bm    <= r1_in.cover_bitmap;
        r2_pay   <= r1_in.payload_bits;
        r2_hi    <= r1_in.cover_high;
        r2_lo    <= r1_in.cover_low;
        r3_st    <= n3_st;
        r3_bm    <= r2_bm;
        r3_hi    <= r2_hi;
        r3_lo    <= r2_lo;
        r4_st    <= r3_st;
        r4_delta <= n4_delta;
        r4_gs    <= n4_gs;
        r4_hi    <= r3_hi;
        r4_lo    <= r3_lo;
        r5_st    <= r4_st;
        r5_p     <= n5_full[23:0];
        r5_hi    <= r4_hi;
        r5_lo    <= r4_lo;
        r6_out   <= n6_out;
    end

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##6 o_done)
        else $error("request did not complete after six cycles");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 6))
        else $error("result without a request");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.stego_high >= o_result.stego_low)
        else $error("levels not ordered");

    a_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.level_spread == o_result.stego_high - o_result.stego_low)
        else $error("spread mismatch");

    a_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in.payload_count == '0 |-> ##6
        o_result.stego_bitmap == $past(i_in.cover_bitmap, 6))
        else $error("bitmap changed with empty payload");
`endif

endmodule
